>>> rtl/core/plhm_pkg.sv
// ----------------------------------------------------------------------------
// plhm_pkg
// Shared types, constants and the dB tick table of the peak-hold level meter.
// ----------------------------------------------------------------------------
package plhm_pkg;

   localparam int CHANNELS_DEF   = 8;
   localparam int TICK_COUNT_DEF = 10;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [11:0] BAR_LENGTH_RESET = 12'd256;
   localparam logic [19:0] HOLD_LIMIT_RESET = 20'd44100;
   localparam logic [20:0] AGE_MAX          = 21'h1FFFFF;

   // 60 dB in Q8 and 20*log10(2) in Q16
   localparam logic [13:0] DB_FLOOR_Q8      = 14'd15360;
   localparam logic [18:0] DB_PER_OCTAVE    = 19'd394566;
   // ceil(2^23/10): exact floor(x/10) for x below 2^22
   localparam logic [19:0] DIV10_MUL        = 20'd838861;

   localparam logic [0:0] CSR_BAR_LENGTH = 1'b0;
   localparam logic [0:0] CSR_HOLD_LIMIT = 1'b1;

   typedef struct packed {
      logic [2:0]  channel;
      logic [15:0] level;
      logic [15:0] peak;
   } q_item_type;

   typedef struct packed {
      logic        start;
      logic [15:0] x;
   } conv_req_type;

   typedef struct packed {
      logic        done;
      logic [11:0] pos;
   } conv_stat_type;

   // tick magnitudes in Q8 dB (negated tick values); past the tenth: 0 dB
   function automatic logic [13:0] tick_mag(input logic [3:0] idx);
      logic [13:0] r;
      unique case (idx)
         4'd0:    r = 14'd15360;
         4'd1:    r = 14'd12800;
         4'd2:    r = 14'd10240;
         4'd3:    r = 14'd7680;
         4'd4:    r = 14'd5120;
         4'd5:    r = 14'd2560;
         4'd6:    r = 14'd1536;
         4'd7:    r = 14'd768;
         4'd8:    r = 14'd256;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/plhm_if.sv
// ----------------------------------------------------------------------------
// plhm_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface plhm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  channel;
   logic [15:0] amplitude;
   logic [15:0] sample_count;

   modport source (output valid, channel, amplitude, sample_count, input ready);
   modport sink   (input valid, channel, amplitude, sample_count, output ready);
endinterface

interface plhm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  channel_out;
   logic [15:0] level;
   logic [15:0] peak;
   logic [11:0] level_position;
   logic [11:0] peak_position;

   modport source (output valid, channel_out, level, peak, level_position,
                   peak_position, input ready);
   modport sink   (input valid, channel_out, level, peak, level_position,
                   peak_position, output ready);
endinterface

>>> rtl/core/plhm_front.sv
// ----------------------------------------------------------------------------
// plhm_front
// Accepts a block peak, updates the channel's level, peak and age state and
// queues the new level and peak for conversion.
// ----------------------------------------------------------------------------
module plhm_front
   import plhm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   plhm_req_if.sink    req,
   input  logic [19:0] hold_limit,
   output logic        push,
   output q_item_type  push_item,
   input  logic        full
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_READ  = 4'b0010,
      F_CALC  = 4'b0100,
      F_WRITE = 4'b1000
   } f_state_type;

   f_state_type state_ff, state_in;

   logic [52:0]   store_ff [CHANNELS];
   logic [52:0]   rd_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic          rd_vld_ff;
   logic [AW-1:0] addr_ff;
   logic          inr_ff;
   logic [2:0]    ch_ff;
   logic [15:0]   amp_ff;
   logic [15:0]   cnt_ff;
   logic [15:0]   old_lvl_ff, old_pk_ff;
   logic [20:0]   old_age_ff;
   logic [39:0]   prod_ff;
   q_item_type    upd_ff, upd_in;
   logic [20:0]   age_ff, age_in;

   logic          accept;
   logic [AW-1:0] req_addr;
   logic [15:0]   rd_lvl, rd_pk;
   logic [20:0]   rd_age;
   logic [19:0]   dsum;
   logic [15:0]   dec;
   logic [21:0]   age_sum;
   logic [20:0]   age_sat;
   logic          rising, release_pk;

   assign req.ready = (state_ff == F_IDLE);
   assign accept    = req.valid && req.ready;
   assign req_addr  = AW'(req.channel);

   assign rd_lvl = rd_vld_ff ? rd_ff[15:0]  : 16'd0;
   assign rd_pk  = rd_vld_ff ? rd_ff[31:16] : 16'd0;
   assign rd_age = rd_vld_ff ? rd_ff[52:32] : 21'd0;
   assign dsum   = 20'(rd_lvl) * 20'd9 + 20'(amp_ff) + 20'd5;

   assign dec        = prod_ff[38:23];
   assign age_sum    = {1'b0, old_age_ff} + 22'(cnt_ff);
   assign age_sat    = age_sum[21] ? AGE_MAX : age_sum[20:0];
   assign rising     = old_lvl_ff < amp_ff;
   assign release_pk = old_age_ff > {1'b0, hold_limit};

   always_comb begin
      upd_in         = upd_ff;
      age_in         = age_ff;
      upd_in.channel = ch_ff;
      if (!inr_ff) begin
         upd_in.level = 16'd0;
         upd_in.peak  = 16'd0;
         age_in       = 21'd0;
      end else if (rising) begin
         upd_in.level = amp_ff;
         if (old_pk_ff < amp_ff || release_pk) begin
            upd_in.peak = amp_ff;
            age_in      = 21'd0;
         end else begin
            upd_in.peak = old_pk_ff;
            age_in      = age_sat;
         end
      end else begin
         upd_in.level = dec;
         if (release_pk) begin
            upd_in.peak = dec;
            age_in      = 21'd0;
         end else begin
            upd_in.peak = old_pk_ff;
            age_in      = age_sat;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (accept) state_in = F_READ;
         F_READ:  state_in = F_CALC;
         F_CALC:  state_in = F_WRITE;
         F_WRITE: if (!full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   assign push      = (state_ff == F_WRITE) && !full;
   assign push_item = upd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (push && inr_ff) valid_ff[addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff     <= req.channel;
         amp_ff    <= req.amplitude;
         cnt_ff    <= req.sample_count;
         addr_ff   <= req_addr;
         inr_ff    <= 32'(req.channel) < CHANNELS;
         rd_ff     <= store_ff[req_addr];
         rd_vld_ff <= valid_ff[req_addr];
      end
      if (state_ff == F_READ) begin
         old_lvl_ff <= rd_lvl;
         old_pk_ff  <= rd_pk;
         old_age_ff <= rd_age;
         prod_ff    <= dsum * DIV10_MUL;
      end
      if (state_ff == F_CALC) begin
         upd_ff <= upd_in;
         age_ff <= age_in;
      end
      if (push && inr_ff) store_ff[addr_ff] <= {age_ff, upd_ff.peak, upd_ff.level};
   end

endmodule

>>> rtl/core/plhm_fifo.sv
// ----------------------------------------------------------------------------
// plhm_fifo
// Short queue between the state-update front and the conversion back end.
// ----------------------------------------------------------------------------
module plhm_fifo
   import plhm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   output logic       full,
   input  logic       pop,
   output q_item_type pop_item,
   output logic       empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   q_item_type    slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;

   assign full     = (32'(count_ff) == DEPTH);
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ff];

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= bump(wr_ff);
         if (pop)  rd_ff <= bump(rd_ff);
         if (push && !pop)      count_ff <= count_ff + CW'(1);
         else if (pop && !push) count_ff <= count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule

>>> rtl/core/plhm_conv.sv
// ----------------------------------------------------------------------------
// plhm_conv
// Amplitude to bar position: log2 by repeated squaring, scale to dB, then a
// piecewise-linear tick mapping; tick scale by reciprocal multiply and the
// interpolation by a restoring divider.
// ----------------------------------------------------------------------------
module plhm_conv
   import plhm_pkg::*;
#(
   parameter int TICK_COUNT = TICK_COUNT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  conv_req_type  creq,
   input  logic [11:0]   bar_length,
   output conv_stat_type cstat
);

   localparam logic [3:0]  TL    = 4'(TICK_COUNT - 1);
   localparam logic [4:0]  LAST  = 5'd25;
   localparam int          TLI   = TICK_COUNT - 1;
   // ceil(2^20/TL): exact floor(x/TL) for x below 2^16
   localparam logic [20:0] RECIP = 21'(((1 << 20) + TLI - 1) / TLI);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_LOG   = 9'b000000010,
      S_MULLO = 9'b000000100,
      S_MULHI = 9'b000001000,
      S_SEG   = 9'b000010000,
      S_SCALE = 9'b000100000,
      S_NUM   = 9'b001000000,
      S_DIV   = 9'b010000000,
      S_DONE  = 9'b100000000
   } c_state_type;

   c_state_type state_ff;
   logic [15:0] m_ff, frac_ff;
   logic [3:0]  e_ff, seg_ff;
   logic [4:0]  cnt_ff;
   logic [29:0] prod_ff;
   logic [13:0] mag_ff;
   logic [12:0] rem_ff, dvs_ff;
   logic [25:0] qd_ff;
   logic [15:0] x1_ff, x2_ff;
   logic [11:0] p1_ff, p2_ff, pos_ff;

   logic        start;
   logic [3:0]  msb;
   logic [31:0] sq;
   logic [16:0] sq_sh;
   logic [15:0] m_next;
   logic [20:0] n_w;
   logic [39:0] acc;
   logic [39:0] rnd;
   logic [15:0] mag_raw;
   logic [13:0] mag_c;
   logic [3:0]  seg_c;
   logic [13:0] rem_sh, rem_n;
   logic        ge;
   logic [25:0] qd_n;
   logic [13:0] lo_mag, hi_mag, dm, den;
   logic [11:0] diff;
   logic [25:0] num;
   logic [36:0] q1, q2;

   assign start = creq.start && (state_ff == S_IDLE || state_ff == S_DONE);

   always_comb begin
      msb = 4'd0;
      for (int k = 0; k < 16; k++) begin
         if (creq.x[k]) msb = 4'(k);
      end
   end

   // one fraction bit per squaring, mantissa kept in [1,2) as Q15
   assign sq     = 32'(m_ff) * 32'(m_ff);
   assign sq_sh  = sq[31:15];
   assign m_next = sq_sh[16] ? sq_sh[16:1] : sq_sh[15:0];

   assign n_w     = {5'd16 - {1'b0, e_ff}, 16'd0} - 21'(frac_ff);
   assign acc     = 40'(prod_ff) +
                    40'({29'(n_w[20:11]) * 29'(DB_PER_OCTAVE), 11'd0});
   assign rnd     = acc + 40'h800000;
   assign mag_raw = rnd[39:24];
   assign mag_c   = (mag_raw > 16'(DB_FLOOR_Q8)) ? DB_FLOOR_Q8 : mag_raw[13:0];

   // first tick above the value, i.e. first magnitude below it
   always_comb begin
      seg_c = 4'd1;
      for (int k = TICK_COUNT - 1; k >= 1; k--) begin
         if (tick_mag(4'(k)) < mag_ff) seg_c = 4'(k);
      end
   end

   assign q1 = 37'(x1_ff) * 37'(RECIP);
   assign q2 = 37'(x2_ff) * 37'(RECIP);

   assign rem_sh = {rem_ff, qd_ff[25]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};
   assign rem_n  = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
   assign qd_n   = {qd_ff[24:0], ge};

   assign lo_mag = tick_mag(seg_ff - 4'd1);
   assign hi_mag = tick_mag(seg_ff);
   assign dm     = lo_mag - mag_ff;
   assign den    = lo_mag - hi_mag;
   assign diff   = p2_ff - p1_ff;
   assign num    = 26'(diff) * 26'(dm);

   assign cstat.done = (state_ff == S_DONE);
   assign cstat.pos  = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE, S_DONE: begin
               if (start) state_ff <= (creq.x == 16'd0) ? S_SEG : S_LOG;
            end
            S_LOG:   if (cnt_ff == 5'd15) state_ff <= S_MULLO;
            S_MULLO: state_ff <= S_MULHI;
            S_MULHI: state_ff <= S_SEG;
            S_SEG: begin
               if (mag_ff >= DB_FLOOR_Q8 || mag_ff <= tick_mag(TL)) state_ff <= S_DONE;
               else state_ff <= S_SCALE;
            end
            S_SCALE: state_ff <= S_NUM;
            S_NUM:   state_ff <= S_DIV;
            S_DIV:   if (cnt_ff == LAST) state_ff <= S_DONE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE, S_DONE: begin
            if (start) begin
               m_ff    <= creq.x << (4'd15 - msb);
               e_ff    <= msb;
               frac_ff <= 16'd0;
               cnt_ff  <= 5'd0;
               mag_ff  <= DB_FLOOR_Q8;
            end
         end
         S_LOG: begin
            m_ff    <= m_next;
            frac_ff <= {frac_ff[14:0], sq_sh[16]};
            cnt_ff  <= cnt_ff + 5'd1;
         end
         S_MULLO: prod_ff <= 30'(n_w[10:0]) * 30'(DB_PER_OCTAVE);
         S_MULHI: mag_ff  <= mag_c;
         S_SEG: begin
            if (mag_ff >= DB_FLOOR_Q8) begin
               pos_ff <= 12'd0;
            end else if (mag_ff <= tick_mag(TL)) begin
               pos_ff <= bar_length;
            end else begin
               seg_ff <= seg_c;
               x1_ff  <= 16'(bar_length) * 16'(seg_c - 4'd1);
               x2_ff  <= 16'(bar_length) * 16'(seg_c);
            end
         end
         S_SCALE: begin
            p1_ff <= q1[31:20];
            p2_ff <= q2[31:20];
         end
         S_NUM: begin
            // round half up: (2*num + den) / (2*den)
            qd_ff  <= {num[24:0], 1'b0} + 26'(den);
            dvs_ff <= {den[11:0], 1'b0};
            rem_ff <= 13'd0;
            cnt_ff <= 5'd0;
         end
         S_DIV: begin
            rem_ff <= rem_n[12:0];
            qd_ff  <= qd_n;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == LAST) pos_ff <= p1_ff + qd_n[11:0];
         end
         default: ;
      endcase
   end

endmodule

>>> rtl/core/plhm_back.sv
// ----------------------------------------------------------------------------
// plhm_back
// Pops queued level/peak pairs, converts both to bar positions in parallel
// and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module plhm_back
   import plhm_pkg::*;
#(
   parameter int TICK_COUNT = TICK_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  q_item_type  pop_item,
   input  logic        empty,
   output logic        pop,
   input  logic [11:0] bar_length,
   plhm_rsp_if.source  rsp
);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RUN  = 2'b10
   } b_state_type;

   b_state_type   state_ff;
   q_item_type    item_ff;
   logic          out_vld_ff;
   logic [2:0]    out_ch_ff;
   logic [15:0]   out_lvl_ff, out_pk_ff;
   logic [11:0]   out_lpos_ff, out_ppos_ff;

   conv_req_type  lreq, preq;
   conv_stat_type lstat, pstat;
   logic          load;
   logic [11:0]   ppos;

   assign pop  = (state_ff == B_IDLE) && !empty;
   assign load = (state_ff == B_RUN) && lstat.done && pstat.done &&
                 (!out_vld_ff || rsp.ready);

   assign lreq.start = pop;
   assign lreq.x     = pop_item.level;
   assign preq.start = pop;
   assign preq.x     = pop_item.peak;

   plhm_conv #(.TICK_COUNT(TICK_COUNT)) u_conv_level (
      .clock(clock), .reset(reset), .creq(lreq), .bar_length(bar_length), .cstat(lstat)
   );

   plhm_conv #(.TICK_COUNT(TICK_COUNT)) u_conv_peak (
      .clock(clock), .reset(reset), .creq(preq), .bar_length(bar_length), .cstat(pstat)
   );

   // keep the peak marker two pixels short of the bar end
   always_comb begin
      ppos = pstat.pos;
      if (({1'b0, pstat.pos} + 13'd2) >= {1'b0, bar_length}) begin
         ppos = (bar_length >= 12'd2) ? bar_length - 12'd2 : 12'd0;
      end
   end

   assign rsp.valid          = out_vld_ff;
   assign rsp.channel_out    = out_ch_ff;
   assign rsp.level          = out_lvl_ff;
   assign rsp.peak           = out_pk_ff;
   assign rsp.level_position = out_lpos_ff;
   assign rsp.peak_position  = out_ppos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            B_IDLE:  if (pop) state_ff <= B_RUN;
            B_RUN:   if (load) state_ff <= B_IDLE;
            default: state_ff <= B_IDLE;
         endcase
         if (load)           out_vld_ff <= 1'b1;
         else if (rsp.ready) out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) item_ff <= pop_item;
      if (load) begin
         out_ch_ff   <= item_ff.channel;
         out_lvl_ff  <= item_ff.level;
         out_pk_ff   <= item_ff.peak;
         out_lpos_ff <= lstat.pos;
         out_ppos_ff <= ppos;
      end
   end

endmodule

>>> rtl/core/peak_hold_level_meter.sv
// Path from request transfer to response valid: front read, calc, write states,
// the queue, then 16 log squaring steps, 2 multiply steps, tick lookup, scale,
// numerator and a 26-step restoring division (skipped at -60 dB or 0 dB; a zero
// value skips the squaring too). Front and back each hold one item at a time.
// Reset: synchronous, active high; per-channel valid bits clear at once, so
// all channel state reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
// peak_hold_level_meter
// Per-channel VU level with peak hold and dB bar position mapping.
// ----------------------------------------------------------------------------
module peak_hold_level_meter
   import plhm_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int TICK_COUNT = TICK_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   plhm_req_if.sink    req_ch,
   plhm_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   logic [11:0] bar_len_ff;
   logic [19:0] hold_ff;
   logic        push, full, pop, empty;
   q_item_type  push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_len_ff <= BAR_LENGTH_RESET;
         hold_ff    <= HOLD_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BAR_LENGTH: bar_len_ff <= csr_wdata[11:0];
            CSR_HOLD_LIMIT: hold_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   plhm_front #(.CHANNELS(CHANNELS)) u_front (
      .clock(clock), .reset(reset), .req(req_ch), .hold_limit(hold_ff),
      .push(push), .push_item(push_item), .full(full)
   );

   plhm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item), .full(full),
      .pop(pop), .pop_item(pop_item), .empty(empty)
   );

   plhm_back #(.TICK_COUNT(TICK_COUNT)) u_back (
      .clock(clock), .reset(reset), .pop_item(pop_item), .empty(empty), .pop(pop),
      .bar_length(bar_len_ff), .rsp(rsp_ch)
   );

endmodule

>>> rtl/core/plhm_checker.sv
// ----------------------------------------------------------------------------
// plhm_checker
// Port-level checks on the response channel of the level meter.
// ----------------------------------------------------------------------------
module plhm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] level,
   input logic [15:0] peak,
   input logic [11:0] level_position,
   input logic [11:0] peak_position
);

   // a stalled transfer keeps its position fields
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(level_position) &&
      $stable(peak_position))
      else $error("response dropped or changed while stalled");

   // held peak never sits below the smoothed level
   a_peak_ge_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> peak >= level)
      else $error("peak below level");

   // silent level maps to the bottom of the bar
   a_zero_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && level == 16'd0 |-> level_position == 12'd0)
      else $error("zero level with nonzero position");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind peak_hold_level_meter plhm_checker u_plhm_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .level(rsp_ch.level),
   .peak(rsp_ch.peak),
   .level_position(rsp_ch.level_position),
   .peak_position(rsp_ch.peak_position)
);
